// ----- hdl/square_matrix_rotator_macros.svh -----
`ifndef SQUARE_MATRIX_ROTATOR_MACROS_SVH
`define SQUARE_MATRIX_ROTATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SMR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SMR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/smr_pkg.sv -----
`default_nettype none
package smr_pkg;

	localparam int MAX_DIM_DEF = 8;
	localparam int PADDR_W     = 3;
	localparam int DATA_W      = 32;
	localparam int ANGLE_W     = 12;
	localparam int DIM_W       = 4;

	localparam int DEG_PER_TURN     = 90;
	localparam int TURNS_PER_CIRCLE = 4;
	// angle / 90 as a multiply by a scaled reciprocal, exact for 12-bit angles
	localparam int RECIP_SHIFT = 18;
	localparam int TURN_RECIP  = (2 ** RECIP_SHIFT + DEG_PER_TURN - 1) / DEG_PER_TURN;
	localparam int TURN_W      = $clog2(TURNS_PER_CIRCLE);

	localparam logic REG_ANGLE = 1'b0;
	localparam logic REG_DIM   = 1'b1;

	typedef enum logic [TURN_W-1:0] {
		ROT_0 = 2'd0,
		ROT_1 = 2'd1,
		ROT_2 = 2'd2,
		ROT_3 = 2'd3
	} rot_t;

	typedef struct packed {
		logic load;
		logic emit_start;
		logic emit;
	} smr_cmd_t;

	typedef struct packed {
		logic emit_due;
		logic last_addr;
	} smr_sts_t;

	// below 90 degrees the quotient is already zero
	function automatic rot_t quarter_turns(input logic [ANGLE_W-1:0] angle);
		logic [2*ANGLE_W-1:0] prod;
		prod = angle * ANGLE_W'(TURN_RECIP);
		return rot_t'(prod[RECIP_SHIFT +: TURN_W]);
	endfunction

endpackage
`default_nettype wire

// ----- hdl/smr_cfg.sv -----
`default_nettype none
module smr_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [smr_pkg::PADDR_W-1:0] paddr,
	input  wire logic [smr_pkg::DATA_W-1:0]  pwdata,
	output logic      [smr_pkg::DATA_W-1:0]  prdata,
	output logic                             pready,
	output logic      [smr_pkg::ANGLE_W-1:0] angle,
	output logic      [smr_pkg::DIM_W-1:0]   dim
);
	import smr_pkg::*;

	logic [ANGLE_W-1:0] angle_q;
	logic [DIM_W-1:0]   dim_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= ANGLE_W'(DEG_PER_TURN);
			dim_q   <= DIM_W'(MAX_DIM_DEF);
		end else if (wr_en) begin
			case (paddr[2])
				REG_ANGLE: angle_q <= pwdata[ANGLE_W-1:0];
				REG_DIM:   dim_q   <= pwdata[DIM_W-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ANGLE: prdata = {{(DATA_W-ANGLE_W){1'b0}}, angle_q};
			REG_DIM:   prdata = {{(DATA_W-DIM_W){1'b0}}, dim_q};
			default:   prdata = '0;
		endcase
	end

	assign angle = angle_q;
	assign dim   = dim_q;

endmodule
`default_nettype wire

// ----- hdl/smr_ctrl.sv -----
`default_nettype none
module smr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire smr_pkg::smr_sts_t sts,
	output smr_pkg::smr_cmd_t      cmd,
	output logic                   busy
);
	import smr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t state_q, state_d;

	assign busy           = (state_q == ST_EMIT);
	assign cmd.load       = start && !busy;
	assign cmd.emit_start = cmd.load && sts.emit_due;
	assign cmd.emit       = (state_q == ST_EMIT);

	always_comb begin
		case (state_q)
			ST_IDLE: state_d = cmd.emit_start ? ST_EMIT : ST_IDLE;
			ST_EMIT: state_d = sts.last_addr ? ST_IDLE : ST_EMIT;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/smr_dp.sv -----
`default_nettype none
module smr_dp #(
	parameter int MAX_DIM = smr_pkg::MAX_DIM_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire smr_pkg::smr_cmd_t                cmd,
	output smr_pkg::smr_sts_t                     sts,
	input  wire logic        [smr_pkg::ANGLE_W-1:0] angle,
	input  wire logic        [smr_pkg::DIM_W-1:0]   dim,
	input  wire logic signed [smr_pkg::DATA_W-1:0]  elem_value,
	output logic                                  out_valid,
	output logic signed      [smr_pkg::DATA_W-1:0]  out_value,
	output logic                                  out_last
);
	import smr_pkg::*;

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SIDE_W = $clog2(MAX_DIM + 1);
	localparam int IW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DX_W   = DIM_W + 1;

	logic [DATA_W-1:0]        store_q [DEPTH];
	logic [CNT_W-1:0]         load_count_q;
	logic [CNT_W-1:0]         load_next;
	logic [IW-1:0]            i_q, j_q;
	rot_t                     rot_q;
	logic [DX_W-1:0]          dim_x, side_x;
	logic [SIDE_W-1:0]        side;
	logic [2*SIDE_W-1:0]      side_sq;
	logic [CNT_W-1:0]         total;
	logic [IW-1:0]            last_idx;
	logic [IW-1:0]            row, col;
	logic [IW+SIDE_W-1:0]     row_base;
	logic [AW-1:0]            rd_addr;
	logic                     room;
	logic                     row_end;
	logic                     valid_s1, last_s1;
	logic [DATA_W-1:0]        rd_data_s1;

	// zero counts as one, larger than the store saturates
	assign dim_x  = {1'b0, dim};
	assign side_x = (dim_x == '0) ? DX_W'(1) :
	                (dim_x > DX_W'(MAX_DIM)) ? DX_W'(MAX_DIM) : dim_x;
	assign side   = SIDE_W'(side_x);
	assign side_sq = side * side;
	assign total  = CNT_W'(side_sq);
	assign last_idx = IW'(side - SIDE_W'(1));

	assign room      = (load_count_q < CNT_W'(DEPTH));
	assign load_next = room ? load_count_q + CNT_W'(1) : load_count_q;

	assign sts.emit_due  = (load_next >= total);
	assign row_end       = (j_q == last_idx);
	assign sts.last_addr = row_end && (i_q == last_idx);

	always_comb begin
		case (rot_q)
			ROT_1: begin
				row = last_idx - j_q;
				col = i_q;
			end
			ROT_2: begin
				row = last_idx - i_q;
				col = last_idx - j_q;
			end
			ROT_3: begin
				row = j_q;
				col = last_idx - i_q;
			end
			default: begin
				row = i_q;
				col = j_q;
			end
		endcase
	end

	assign row_base = row * side;
	assign rd_addr  = AW'(row_base + (IW+SIDE_W)'(col));

	always_ff @(posedge clk) begin
		if (cmd.load && room) begin
			store_q[load_count_q[AW-1:0]] <= elem_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rd_data_s1 <= store_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
			i_q          <= '0;
			j_q          <= '0;
			rot_q        <= ROT_0;
			valid_s1     <= 1'b0;
			last_s1      <= 1'b0;
		end else begin
			if (cmd.load) begin
				load_count_q <= sts.emit_due ? '0 : load_next;
			end
			if (cmd.emit_start) begin
				i_q   <= '0;
				j_q   <= '0;
				rot_q <= quarter_turns(angle);
			end else if (cmd.emit) begin
				if (row_end) begin
					j_q <= '0;
					i_q <= i_q + IW'(1);
				end else begin
					j_q <= j_q + IW'(1);
				end
			end
			valid_s1 <= cmd.emit;
			last_s1  <= cmd.emit && sts.last_addr;
		end
	end

	assign out_valid = valid_s1;
	assign out_value = rd_data_s1;
	assign out_last  = last_s1;

endmodule
`default_nettype wire

// ----- hdl/square_matrix_rotator.sv -----
// Square matrix rotator. Write angle_degrees (byte 0) and dim (byte 4) while
// idle, then feed dim*dim elements row-major, one per cycle, with start while
// busy is low. The word that completes the matrix starts the output: busy is
// high while the matrix is read out, one store read per cycle from its single
// read port, and each word appears on out_value in the cycle after its read,
// marked by a one-cycle out_valid, out_last on the final one. The receiver
// cannot stall, so it must take every word on the cycle it is strobed. The
// store is not cleared at reset.
`include "square_matrix_rotator_macros.svh"
`default_nettype none
module square_matrix_rotator #(
	parameter int MAX_DIM = smr_pkg::MAX_DIM_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic        [smr_pkg::PADDR_W-1:0] paddr,
	input  wire logic        [smr_pkg::DATA_W-1:0]  pwdata,
	output logic             [smr_pkg::DATA_W-1:0]  prdata,
	output logic                                   pready,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic signed [smr_pkg::DATA_W-1:0]  elem_value,
	output logic                                   out_valid,
	output logic signed      [smr_pkg::DATA_W-1:0]  out_value,
	output logic                                   out_last
);
	import smr_pkg::*;

	logic [ANGLE_W-1:0] angle;
	logic [DIM_W-1:0]   dim;
	smr_cmd_t           cmd;
	smr_sts_t           sts;

	smr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.angle   (angle),
		.dim     (dim)
	);

	smr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	smr_dp #(
		.MAX_DIM (MAX_DIM)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.angle      (angle),
		.dim        (dim),
		.elem_value (elem_value),
		.out_valid  (out_valid),
		.out_value  (out_value),
		.out_last   (out_last)
	);

	`SMR_ASSERT_NXT(a_busy_gives_word, busy, out_valid, "busy cycle produced no output word")
	`SMR_ASSERT_IMP(a_word_follows_busy, out_valid, $past(busy), "output word without a read")
	`SMR_ASSERT_IMP(a_last_ends_busy, out_valid && out_last, !busy, "busy held past final word")
	`SMR_ASSERT_NXT(a_start_completes, busy && !out_valid, out_valid, "output stream broken")

endmodule
`default_nettype wire
